FILE: src/cmstk_pkg.sv
// ----------------------------------------------------------------------------
// cmstk_pkg: shared types and constants of the count-min sketch block
// Field widths, request and register codes, sequencer states, result record
// and the ranking rule of the top-k list.
// ----------------------------------------------------------------------------
package cmstk_pkg;

    localparam int KEY_W      = 64;
    localparam int EST_W      = 32;
    localparam int COEF_W     = 31;
    localparam int REQ_W      = 2;
    localparam int RSEL_W     = 3;
    localparam int RANK_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [31:0] HASH_PRIME = 32'h7FFF_FFFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_LOAD  = 2'd2,
        REQ_DUMP  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS  = 2'd0,
        CFG_COLS  = 2'd1,
        CFG_TRACK = 2'd2,
        CFG_TOPK  = 2'd3
    } t_cfg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_FOLD,
        ST_MOD,
        ST_RD,
        ST_WAIT,
        ST_SCAN,
        ST_DECIDE,
        ST_ACK,
        ST_DSCAN,
        ST_DEMIT
    } t_state;

    typedef struct packed {
        logic [EST_W-1:0]  estimate;
        logic              listed;
        logic              inserted;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic              entry_valid;
        logic [RANK_W-1:0] entry_rank;
        logic [KEY_W-1:0]  entry_key;
        logic [EST_W-1:0]  entry_count;
        logic              last;
    } t_res;

    // Entry a ranks below entry b: lower count, or same count and smaller key.
    function automatic logic ranks_below(input logic [EST_W-1:0] ca,
                                         input logic [KEY_W-1:0] ka,
                                         input logic [EST_W-1:0] cb,
                                         input logic [KEY_W-1:0] kb);
        if (ca != cb) begin
            return ca < cb;
        end
        return ka < kb;
    endfunction

endpackage

FILE: src/cmstk_req_if.sv
// ----------------------------------------------------------------------------
// cmstk_req_if: request channel of the count-min sketch block
// Valid/ready handshake with the request fields as payload.
// ----------------------------------------------------------------------------
interface cmstk_req_if;
    logic                            valid;
    logic                            ready;
    logic [cmstk_pkg::REQ_W-1:0]     req_type;
    logic [cmstk_pkg::KEY_W-1:0]     item_key;
    logic [cmstk_pkg::RSEL_W-1:0]    row_select;
    logic [cmstk_pkg::COEF_W-1:0]    coeff_mult;
    logic [cmstk_pkg::COEF_W-1:0]    coeff_offset;

    modport source (output valid, req_type, item_key, row_select, coeff_mult, coeff_offset,
                    input ready);
    modport sink (input valid, req_type, item_key, row_select, coeff_mult, coeff_offset,
                  output ready);
endinterface

FILE: src/cmstk_res_if.sv
// ----------------------------------------------------------------------------
// cmstk_res_if: result channel of the count-min sketch block
// Valid/ready handshake with the result fields as payload.
// ----------------------------------------------------------------------------
interface cmstk_res_if;
    logic                            valid;
    logic                            ready;
    logic [cmstk_pkg::EST_W-1:0]     estimate;
    logic                            listed;
    logic                            inserted;
    logic                            evicted;
    logic [cmstk_pkg::KEY_W-1:0]     evicted_key;
    logic                            entry_valid;
    logic [cmstk_pkg::RANK_W-1:0]    entry_rank;
    logic [cmstk_pkg::KEY_W-1:0]     entry_key;
    logic [cmstk_pkg::EST_W-1:0]     entry_count;
    logic                            last;

    modport source (output valid, estimate, listed, inserted, evicted, evicted_key,
                    entry_valid, entry_rank, entry_key, entry_count, last,
                    input ready);
    modport sink (input valid, estimate, listed, inserted, evicted, evicted_key,
                  entry_valid, entry_rank, entry_key, entry_count, last,
                  output ready);
endinterface

FILE: src/cmstk_ram.sv
// ----------------------------------------------------------------------------
// cmstk_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cmstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/count_min_sketch_topk.sv
// ----------------------------------------------------------------------------
// count_min_sketch_topk: count-min sketch of 64-bit keys with a top-k list
// Add and query walk each active row through hash, modulo and counter access, then
// scan the filled list entries and issue the result; load issues a bare acknowledge;
// dump scans the list once per emitted entry. One request is in flight at a time.
// Throughput is set by the shared 31x32 hash multiplier, the 4-bit-per-cycle
// modulo unit and the one-write, one-read counter RAM, all walked row by row.
// After reset the counter RAM is swept to zero, one word a cycle
// (MAX_ROWS * 2**clog2(MAX_COLS) words, 8192 by default); no request is taken then.
// ----------------------------------------------------------------------------
module count_min_sketch_topk #(
    parameter int MAX_ROWS     = 8,
    parameter int MAX_COLS     = 1024,
    parameter int TOPK_MAX     = 16,
    parameter int COUNTER_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cmstk_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cmstk_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    cmstk_req_if.sink                           i_req,
    cmstk_res_if.source                         o_res
);

    localparam int RIDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW       = $clog2(MAX_ROWS + 1);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CLW       = $clog2(MAX_COLS + 1);
    localparam int KIDX_W    = (TOPK_MAX > 1) ? $clog2(TOPK_MAX) : 1;
    localparam int KCW       = $clog2(TOPK_MAX + 1);
    localparam int RAM_DEPTH = MAX_ROWS * (2 ** COL_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int KEY_W     = cmstk_pkg::KEY_W;
    localparam int EST_W     = cmstk_pkg::EST_W;
    localparam int COEF_W    = cmstk_pkg::COEF_W;

    // Configuration registers
    logic [3:0]  r_rows_in_use;
    logic [10:0] r_cols_in_use;
    logic        r_track_mode;
    logic [4:0]  r_topk_size;

    // Sequencer and hash datapath
    cmstk_pkg::t_state r_state, n_state;
    cmstk_pkg::t_req   r_req;
    logic [RAM_AW-1:0] r_clr_addr;
    logic [KEY_W-1:0]  r_key;
    logic [RIDX_W-1:0] r_row;
    logic [COEF_W-1:0] r_hmul [MAX_ROWS];
    logic [COEF_W-1:0] r_hadd [MAX_ROWS];
    logic [62:0]       r_plo;
    logic [31:0]       r_phi;
    logic [63:0]       r_h;
    logic [31:0]       r_x;
    logic [CLW-1:0]    r_rem;
    logic [2:0]        r_step;
    logic [COL_W-1:0]  r_col;
    logic [COUNTER_BITS-1:0] r_min;

    // Top-k list
    logic [KEY_W-1:0]  r_tk_key [TOPK_MAX];
    logic [EST_W-1:0]  r_tk_cnt [TOPK_MAX];
    logic [KCW-1:0]    r_fill;
    logic [KIDX_W-1:0] r_idx;
    logic              r_found;
    logic [KIDX_W-1:0] r_pos;
    logic [KIDX_W-1:0] r_low;
    logic [KEY_W-1:0]  r_low_key;
    logic [EST_W-1:0]  r_low_cnt;
    logic [TOPK_MAX-1:0] r_emitted;
    logic [KCW-1:0]    r_rank;
    logic              r_best_ok;
    logic [KIDX_W-1:0] r_best;
    logic [KEY_W-1:0]  r_best_key;
    logic [EST_W-1:0]  r_best_cnt;

    // Output register
    cmstk_pkg::t_res   r_res, n_res;
    logic              r_ovalid, n_ovalid;

    // Combinational signals
    logic [RCW-1:0]    w_rows;
    logic [CLW-1:0]    w_cols;
    logic [KCW-1:0]    w_ksize;
    logic              w_free;
    logic              w_accept;
    logic              w_last_row;
    logic              w_last_idx;
    logic [31:0]       w_mul_b;
    logic [62:0]       w_mul;
    logic [32:0]       w_fs;
    logic [31:0]       w_fs2;
    logic [30:0]       w_fold;
    logic [CLW:0]      w_t;
    logic [CLW-1:0]    w_rem_nx;
    logic              w_ram_we;
    logic [RAM_AW-1:0] w_ram_waddr;
    logic [COUNTER_BITS-1:0] w_ram_wdata;
    logic [RAM_AW-1:0] w_ram_raddr;
    logic [COUNTER_BITS-1:0] w_rdata;
    logic [COUNTER_BITS-1:0] w_cinc;
    logic [COUNTER_BITS-1:0] w_cur;
    logic [63:0]       w_min64;
    logic [EST_W-1:0]  w_est;
    logic [KEY_W-1:0]  w_ekey;
    logic [EST_W-1:0]  w_ecnt;

    // Register values out of range act as the nearest legal value.
    always_comb begin
        if (r_rows_in_use == 4'd0) begin
            w_rows = RCW'(1);
        end else if (32'(r_rows_in_use) > MAX_ROWS) begin
            w_rows = RCW'(MAX_ROWS);
        end else begin
            w_rows = RCW'(r_rows_in_use);
        end
        if (r_cols_in_use == 11'd0) begin
            w_cols = CLW'(1);
        end else if (32'(r_cols_in_use) > MAX_COLS) begin
            w_cols = CLW'(MAX_COLS);
        end else begin
            w_cols = CLW'(r_cols_in_use);
        end
        if (r_topk_size == 5'd0) begin
            w_ksize = KCW'(1);
        end else if (32'(r_topk_size) > TOPK_MAX) begin
            w_ksize = KCW'(TOPK_MAX);
        end else begin
            w_ksize = KCW'(r_topk_size);
        end
    end

    assign w_free     = !r_ovalid || o_res.ready;
    assign w_accept   = i_req.valid && (r_state == cmstk_pkg::ST_IDLE);
    assign w_last_row = (32'(r_row) + 32'd1) == 32'(w_rows);
    assign w_last_idx = (32'(r_idx) + 32'd1) == 32'(r_fill);

    // Shared multiplier: low then high half of the key.
    assign w_mul_b = (r_state == cmstk_pkg::ST_MUL_LO) ? r_key[31:0] : r_key[63:32];
    assign w_mul   = 63'(r_hmul[r_row]) * 63'(w_mul_b);

    // Since 2^31 is 1 modulo the prime, the 64-bit hash folds in 31-bit pieces.
    assign w_fs   = 33'(r_h[30:0]) + 33'(r_h[61:31]) + 33'(r_h[63:62]);
    assign w_fs2  = 32'(w_fs[30:0]) + 32'(w_fs[32:31]);
    assign w_fold = (w_fs2 >= cmstk_pkg::HASH_PRIME) ?
                    31'(w_fs2 - cmstk_pkg::HASH_PRIME) : w_fs2[30:0];

    // Restoring remainder, four dividend bits per cycle.
    always_comb begin
        w_rem_nx = r_rem;
        w_t      = '0;
        for (int j = 0; j < 4; j++) begin
            w_t = {w_rem_nx, r_x[31-j]};
            if (w_t >= {1'b0, w_cols}) begin
                w_t = w_t - {1'b0, w_cols};
            end
            w_rem_nx = w_t[CLW-1:0];
        end
    end

    assign w_cinc  = (&w_rdata) ? w_rdata : w_rdata + COUNTER_BITS'(1);
    assign w_cur   = (r_req == cmstk_pkg::REQ_ADD) ? w_cinc : w_rdata;
    assign w_min64 = 64'(r_min);
    assign w_est   = w_min64[EST_W-1:0];
    assign w_ekey  = r_tk_key[r_idx];
    assign w_ecnt  = r_tk_cnt[r_idx];

    cmstk_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_counters (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmstk_pkg::ST_CLEAR: begin
                if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                    n_state = cmstk_pkg::ST_IDLE;
                end
            end
            cmstk_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (cmstk_pkg::t_req'(i_req.req_type))
                        cmstk_pkg::REQ_LOAD: n_state = cmstk_pkg::ST_ACK;
                        cmstk_pkg::REQ_DUMP: begin
                            n_state = (r_fill != '0) ? cmstk_pkg::ST_DSCAN
                                                     : cmstk_pkg::ST_DEMIT;
                        end
                        default: n_state = cmstk_pkg::ST_MUL_LO;
                    endcase
                end
            end
            cmstk_pkg::ST_MUL_LO: n_state = cmstk_pkg::ST_MUL_HI;
            cmstk_pkg::ST_MUL_HI: n_state = cmstk_pkg::ST_SUM;
            cmstk_pkg::ST_SUM:    n_state = cmstk_pkg::ST_FOLD;
            cmstk_pkg::ST_FOLD:   n_state = cmstk_pkg::ST_MOD;
            cmstk_pkg::ST_MOD: begin
                if (r_step == 3'd7) begin
                    n_state = cmstk_pkg::ST_RD;
                end
            end
            cmstk_pkg::ST_RD: n_state = cmstk_pkg::ST_WAIT;
            cmstk_pkg::ST_WAIT: begin
                if (!w_last_row) begin
                    n_state = cmstk_pkg::ST_MUL_LO;
                end else if (r_fill != '0) begin
                    n_state = cmstk_pkg::ST_SCAN;
                end else begin
                    n_state = cmstk_pkg::ST_DECIDE;
                end
            end
            cmstk_pkg::ST_SCAN: begin
                if (w_last_idx) begin
                    n_state = cmstk_pkg::ST_DECIDE;
                end
            end
            cmstk_pkg::ST_DECIDE, cmstk_pkg::ST_ACK: begin
                if (w_free) begin
                    n_state = cmstk_pkg::ST_IDLE;
                end
            end
            cmstk_pkg::ST_DSCAN: begin
                if (w_last_idx) begin
                    n_state = cmstk_pkg::ST_DEMIT;
                end
            end
            cmstk_pkg::ST_DEMIT: begin
                if (w_free) begin
                    if (r_fill == '0 || (32'(r_rank) + 32'd1) == 32'(r_fill)) begin
                        n_state = cmstk_pkg::ST_IDLE;
                    end else begin
                        n_state = cmstk_pkg::ST_DSCAN;
                    end
                end
            end
            default: n_state = cmstk_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_req.ready = (r_state == cmstk_pkg::ST_IDLE);
        w_ram_we    = 1'b0;
        w_ram_waddr = r_clr_addr;
        w_ram_wdata = '0;
        w_ram_raddr = RAM_AW'({r_row, r_col});
        if (r_state == cmstk_pkg::ST_CLEAR) begin
            w_ram_we = 1'b1;
        end else if (r_state == cmstk_pkg::ST_WAIT && r_req == cmstk_pkg::REQ_ADD) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = RAM_AW'({r_row, r_col});
            w_ram_wdata = w_cinc;
        end
    end

    // Next result item and its valid flag
    always_comb begin
        n_ovalid = r_ovalid && !o_res.ready;
        n_res    = r_res;
        if (w_free) begin
            unique case (r_state)
                cmstk_pkg::ST_DECIDE: begin
                    n_ovalid       = 1'b1;
                    n_res          = '0;
                    n_res.estimate = w_est;
                    n_res.last     = 1'b1;
                    n_res.listed   = r_found;
                    if (r_req == cmstk_pkg::REQ_ADD && r_track_mode && !r_found) begin
                        if (r_fill < w_ksize) begin
                            n_res.listed   = 1'b1;
                            n_res.inserted = 1'b1;
                        end else if (r_fill != '0 && r_low_cnt < w_est) begin
                            n_res.listed      = 1'b1;
                            n_res.inserted    = 1'b1;
                            n_res.evicted     = 1'b1;
                            n_res.evicted_key = r_low_key;
                        end
                    end
                end
                cmstk_pkg::ST_ACK: begin
                    n_ovalid   = 1'b1;
                    n_res      = '0;
                    n_res.last = 1'b1;
                end
                cmstk_pkg::ST_DEMIT: begin
                    n_ovalid = 1'b1;
                    n_res    = '0;
                    if (r_fill == '0) begin
                        n_res.last = 1'b1;
                    end else begin
                        n_res.entry_valid = 1'b1;
                        n_res.entry_rank  = cmstk_pkg::RANK_W'(32'(r_rank) + 32'd1);
                        n_res.entry_key   = r_best_key;
                        n_res.entry_count = r_best_cnt;
                        n_res.last        = (32'(r_rank) + 32'd1) == 32'(r_fill);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.estimate    = r_res.estimate;
    assign o_res.listed      = r_res.listed;
    assign o_res.inserted    = r_res.inserted;
    assign o_res.evicted     = r_res.evicted;
    assign o_res.evicted_key = r_res.evicted_key;
    assign o_res.entry_valid = r_res.entry_valid;
    assign o_res.entry_rank  = r_res.entry_rank;
    assign o_res.entry_key   = r_res.entry_key;
    assign o_res.entry_count = r_res.entry_count;
    assign o_res.last        = r_res.last;

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cmstk_pkg::ST_CLEAR;
            r_clr_addr    <= '0;
            r_rows_in_use <= 4'd7;
            r_cols_in_use <= 11'd91;
            r_track_mode  <= 1'b1;
            r_topk_size   <= 5'd16;
            r_fill        <= '0;
            r_ovalid      <= 1'b0;
            r_emitted     <= '0;
            for (int i = 0; i < MAX_ROWS; i++) begin
                r_hmul[i] <= '0;
                r_hadd[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_res    <= n_res;

            if (i_cfg_we) begin
                unique case (cmstk_pkg::t_cfg'(i_cfg_idx))
                    cmstk_pkg::CFG_ROWS:  r_rows_in_use <= i_cfg_data[3:0];
                    cmstk_pkg::CFG_COLS:  r_cols_in_use <= i_cfg_data;
                    cmstk_pkg::CFG_TRACK: r_track_mode  <= i_cfg_data[0];
                    cmstk_pkg::CFG_TOPK:  r_topk_size   <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                cmstk_pkg::ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + RAM_AW'(1);
                end
                cmstk_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_req      <= cmstk_pkg::t_req'(i_req.req_type);
                        r_key      <= i_req.item_key;
                        r_row      <= '0;
                        r_min      <= '1;
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_rank     <= '0;
                        r_best_ok  <= 1'b0;
                        r_emitted  <= '0;
                        if (cmstk_pkg::t_req'(i_req.req_type) == cmstk_pkg::REQ_LOAD &&
                            32'(i_req.row_select) < MAX_ROWS) begin
                            r_hmul[RIDX_W'(i_req.row_select)] <= i_req.coeff_mult;
                            r_hadd[RIDX_W'(i_req.row_select)] <= i_req.coeff_offset;
                        end
                    end
                end
                cmstk_pkg::ST_MUL_LO: r_plo <= w_mul;
                cmstk_pkg::ST_MUL_HI: r_phi <= w_mul[31:0];
                cmstk_pkg::ST_SUM: begin
                    r_h <= 64'(r_plo) + {r_phi, 32'd0} + 64'(r_hadd[r_row]);
                end
                cmstk_pkg::ST_FOLD: begin
                    r_x    <= {1'b0, w_fold};
                    r_rem  <= '0;
                    r_step <= '0;
                end
                cmstk_pkg::ST_MOD: begin
                    r_x    <= r_x << 4;
                    r_rem  <= w_rem_nx;
                    r_step <= r_step + 3'd1;
                    r_col  <= COL_W'(w_rem_nx);
                end
                cmstk_pkg::ST_RD: ;
                cmstk_pkg::ST_WAIT: begin
                    if (w_cur < r_min) begin
                        r_min <= w_cur;
                    end
                    r_row <= r_row + RIDX_W'(1);
                end
                cmstk_pkg::ST_SCAN: begin
                    if (w_ekey == r_key) begin
                        r_found <= 1'b1;
                        r_pos   <= r_idx;
                    end
                    if (r_idx == '0 ||
                        cmstk_pkg::ranks_below(w_ecnt, w_ekey, r_low_cnt, r_low_key)) begin
                        r_low     <= r_idx;
                        r_low_cnt <= w_ecnt;
                        r_low_key <= w_ekey;
                    end
                    r_idx <= r_idx + KIDX_W'(1);
                end
                cmstk_pkg::ST_DECIDE: begin
                    if (w_free && r_req == cmstk_pkg::REQ_ADD && r_track_mode) begin
                        if (r_found) begin
                            r_tk_cnt[r_pos] <= w_est;
                        end else if (r_fill < w_ksize) begin
                            r_tk_key[KIDX_W'(r_fill)] <= r_key;
                            r_tk_cnt[KIDX_W'(r_fill)] <= w_est;
                            r_fill             <= r_fill + KCW'(1);
                        end else if (r_fill != '0 && r_low_cnt < w_est) begin
                            // The lowest entry gives way to the new key.
                            r_tk_key[r_low]   <= r_key;
                            r_tk_cnt[r_low]   <= w_est;
                        end
                    end
                end
                cmstk_pkg::ST_ACK: ;
                cmstk_pkg::ST_DSCAN: begin
                    // Pick the highest-ranked entry not yet sent; keys are unique.
                    if (!r_emitted[r_idx] && (!r_best_ok ||
                        !cmstk_pkg::ranks_below(w_ecnt, w_ekey, r_best_cnt, r_best_key))) begin
                        r_best_ok  <= 1'b1;
                        r_best     <= r_idx;
                        r_best_cnt <= w_ecnt;
                        r_best_key <= w_ekey;
                    end
                    r_idx <= r_idx + KIDX_W'(1);
                end
                cmstk_pkg::ST_DEMIT: begin
                    if (w_free && r_fill != '0) begin
                        r_emitted[r_best]   <= 1'b1;
                        r_rank              <= r_rank + KCW'(1);
                        r_idx               <= '0;
                        r_best_ok           <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // The list never holds more entries than it has room for.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= TOPK_MAX)
        else $error("top-k fill exceeds list size");

    // No request is taken while the counter store is being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmstk_pkg::ST_CLEAR) |-> !i_req.ready)
        else $error("request accepted during clearing pass");

    // The remainder stays below the column count throughout the modulo steps.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmstk_pkg::ST_MOD) |-> (r_rem < w_cols))
        else $error("modulo remainder out of range");

    // An accepted item always starts work.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != cmstk_pkg::ST_IDLE))
        else $error("accepted item left the sequencer idle");

    // A result is only loaded when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_res.ready) |=> $stable(r_res))
        else $error("pending result overwritten");

endmodule

FILE: tb/sv/count_min_sketch_topk_test.sv
// ----------------------------------------------------------------------------
// count_min_sketch_topk_test: self-checking bench of the count-min sketch
// Drives add, query, coefficient-load and dump requests through the valid/ready
// channels under random idling, keeps its own copy of the sketch and top-k list,
// and compares every result with the value it predicts, field by field.
// ----------------------------------------------------------------------------
module count_min_sketch_topk_test;

    localparam int N_ROWS       = 8;
    localparam int N_COLS       = 1024;
    localparam int N_LIST       = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 400;
    localparam logic [63:0] MOD_PRIME = 64'd2147483647;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [cmstk_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [cmstk_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    cmstk_req_if req_ch ();
    cmstk_res_if res_ch ();

    count_min_sketch_topk u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the sketch, coefficients, list and registers.
    logic [31:0] sk_count [N_ROWS][N_COLS];
    logic [30:0] sk_mult [N_ROWS];
    logic [30:0] sk_add [N_ROWS];
    logic [63:0] list_key [N_LIST];
    logic [31:0] list_cnt [N_LIST];
    int unsigned list_fill;
    int unsigned reg_rows, reg_cols, reg_track, reg_topk;

    cmstk_pkg::t_res expected_q[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    int unsigned burst_left = 0;
    bit no_gaps = 1'b0;
    logic [63:0] key_pool [24];

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("count_min_sketch_topk: mismatch");
            $finish;
        end
    end

    // Receiver: the stall pattern steps through four modes; a long hold overrides it.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            case ((cycle_count / 64) % 4)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= $urandom_range(0, 1);
                2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default: res_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        cmstk_pkg::t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("result item with no expectation waiting");
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("estimate", want.estimate, res_ch.estimate);
                check_field("listed", want.listed, res_ch.listed);
                check_field("inserted", want.inserted, res_ch.inserted);
                check_field("evicted", want.evicted, res_ch.evicted);
                check_field("evicted_key", want.evicted_key, res_ch.evicted_key);
                check_field("entry_valid", want.entry_valid, res_ch.entry_valid);
                check_field("entry_rank", want.entry_rank, res_ch.entry_rank);
                check_field("entry_key", want.entry_key, res_ch.entry_key);
                check_field("entry_count", want.entry_count, res_ch.entry_count);
                check_field("last", want.last, res_ch.last);
            end
        end
    end

    // Appends one expected result item to the tail of the queue.
    task automatic queue_result(input cmstk_pkg::t_res r);
        expected_q = {expected_q, r};
    endtask

    function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned column_of(input int r, input logic [63:0] key,
                                              input int unsigned cols);
        logic [63:0] h;
        h = {33'd0, sk_mult[r]} * key + {33'd0, sk_add[r]};
        return int'((h % MOD_PRIME) % cols);
    endfunction

    function automatic logic entry_lower(input int a, input int b);
        if (list_cnt[a] != list_cnt[b]) return list_cnt[a] < list_cnt[b];
        return list_key[a] < list_key[b];
    endfunction

    // Applies one accepted request to the shadow state and queues its results.
    task automatic predict_request(input cmstk_pkg::t_req rq, input logic [63:0] key,
                                   input logic [2:0] rsel, input logic [30:0] cm,
                                   input logic [30:0] co);
        cmstk_pkg::t_res r;
        int unsigned rows, cols, ksize, n, low, c, j;
        int pos;
        logic [31:0] est;
        int order [N_LIST];
        rows = clamp_reg(reg_rows, N_ROWS);
        cols = clamp_reg(reg_cols, N_COLS);
        ksize = clamp_reg(reg_topk, N_LIST);
        r = '0;
        case (rq)
            cmstk_pkg::REQ_LOAD: begin
                sk_mult[rsel] = cm;
                sk_add[rsel] = co;
                r.last = 1'b1;
                queue_result(r);
            end
            cmstk_pkg::REQ_DUMP: begin
                n = (list_fill < N_LIST) ? list_fill : N_LIST;
                if (n == 0) begin
                    r.last = 1'b1;
                    queue_result(r);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        j = i;
                        while (j > 0 && entry_lower(order[j-1], i)) begin
                            order[j] = order[j-1];
                            j--;
                        end
                        order[j] = i;
                    end
                    for (int i = 0; i < n; i++) begin
                        r = '0;
                        r.entry_valid = 1'b1;
                        r.entry_rank = cmstk_pkg::RANK_W'(i + 1);
                        r.entry_key = list_key[order[i]];
                        r.entry_count = list_cnt[order[i]];
                        r.last = (i + 1 == n);
                        queue_result(r);
                    end
                end
            end
            default: begin
                if (rq == cmstk_pkg::REQ_ADD) begin
                    for (int i = 0; i < rows; i++) begin
                        c = column_of(i, key, cols);
                        if (sk_count[i][c] != 32'hFFFF_FFFF) sk_count[i][c]++;
                    end
                end
                est = 32'hFFFF_FFFF;
                for (int i = 0; i < rows; i++) begin
                    c = column_of(i, key, cols);
                    if (sk_count[i][c] < est) est = sk_count[i][c];
                end
                pos = -1;
                for (int i = 0; i < list_fill && i < N_LIST; i++)
                    if (pos < 0 && list_key[i] == key) pos = i;
                if (rq == cmstk_pkg::REQ_ADD && reg_track != 0) begin
                    if (pos >= 0) begin
                        list_cnt[pos] = est;
                    end else if (list_fill < ksize) begin
                        list_key[list_fill] = key;
                        list_cnt[list_fill] = est;
                        pos = list_fill;
                        list_fill++;
                        r.inserted = 1'b1;
                    end else if (list_fill > 0) begin
                        n = (list_fill < N_LIST) ? list_fill : N_LIST;
                        low = 0;
                        for (int i = 1; i < n; i++)
                            if (entry_lower(i, low)) low = i;
                        if (list_cnt[low] < est) begin
                            r.evicted = 1'b1;
                            r.evicted_key = list_key[low];
                            r.inserted = 1'b1;
                            list_key[low] = key;
                            list_cnt[low] = est;
                            pos = low;
                        end
                    end
                end
                r.estimate = est;
                r.listed = (pos >= 0);
                r.last = 1'b1;
                queue_result(r);
            end
        endcase
    endtask

    // Offers one item and holds it until accepted; gaps fall between bursts.
    task automatic send_item(input cmstk_pkg::t_req rq, input logic [63:0] key,
                             input logic [2:0] rsel, input logic [30:0] cm,
                             input logic [30:0] co);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rq;
        req_ch.item_key <= key;
        req_ch.row_select <= rsel;
        req_ch.coeff_mult <= cm;
        req_ch.coeff_offset <= co;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_request(rq, key, rsel, cm, co);
        if (!no_gaps && burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 10);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    task automatic send_add(input logic [63:0] key);
        send_item(cmstk_pkg::REQ_ADD, key, 3'($urandom), 31'($urandom), 31'($urandom));
    endtask

    task automatic send_query(input logic [63:0] key);
        send_item(cmstk_pkg::REQ_QUERY, key, 3'($urandom), 31'($urandom), 31'($urandom));
    endtask

    task automatic send_dump();
        send_item(cmstk_pkg::REQ_DUMP, rand_key(), 3'($urandom), 31'($urandom),
                  31'($urandom));
    endtask

    task automatic send_load(input logic [2:0] rsel, input logic [30:0] cm,
                             input logic [30:0] co);
        send_item(cmstk_pkg::REQ_LOAD, rand_key(), rsel, cm, co);
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register; the caller drops the write enable afterwards.
    task automatic write_reg(input cmstk_pkg::t_cfg idx,
                             input logic [cmstk_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            cmstk_pkg::CFG_ROWS: reg_rows = data[3:0];
            cmstk_pkg::CFG_COLS: reg_cols = data[10:0];
            cmstk_pkg::CFG_TRACK: reg_track = data[0];
            default: reg_topk = data[4:0];
        endcase
    endtask

    task automatic set_config(input int unsigned rows, input int unsigned cols,
                              input int unsigned track, input int unsigned topk);
        write_reg(cmstk_pkg::CFG_ROWS, cmstk_pkg::CFG_DATA_W'(rows));
        write_reg(cmstk_pkg::CFG_COLS, cmstk_pkg::CFG_DATA_W'(cols));
        write_reg(cmstk_pkg::CFG_TRACK, cmstk_pkg::CFG_DATA_W'(track));
        write_reg(cmstk_pkg::CFG_TOPK, cmstk_pkg::CFG_DATA_W'(topk));
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_basic_requests();
        send_dump();                      // empty list gives a single empty item
        send_add(64'd0);                  // all coefficients zero: every key collides
        send_add('1);
        send_query(64'h1234);
        send_load(3'd0, 31'h7FFF_FFFE, 31'h7FFF_FFFE);
        send_load(3'd1, 31'd0, 31'd0);
        for (int i = 2; i < N_ROWS; i++)
            send_load(3'(i), 31'($urandom_range(0, 2147483646)),
                      31'($urandom_range(0, 2147483646)));
        send_add(64'h8000_0000_0000_0000);
        send_add(64'd0);
        send_add('1);
        send_query(64'd0);
        send_query(rand_key());
        send_dump();
        drain();
    endtask

    task automatic test_counting_only();
        set_config(7, 91, 0, 16);
        send_add(64'd77);
        send_add(64'd0);
        send_query(64'd0);
        send_dump();
        drain();
    endtask

    task automatic test_register_extremes();
        set_config(0, 0, 1, 0);
        send_add(64'd5);
        send_add(64'd6);
        send_dump();
        drain();
        set_config(15, 2047, 1, 31);
        send_add(64'd5);
        send_query(64'd6);
        drain();
        set_config(8, 1024, 1, 16);
        send_add(rand_key());
        send_dump();
        drain();
        set_config(1, 1, 1, 1);
        send_add(64'd9);
        send_add(64'd10);
        drain();
    endtask

    // Fills the list, then shrinks the kept size below the fill.
    task automatic test_shrunk_list();
        set_config(2, 4, 1, 16);
        for (int i = 0; i < 20; i++) send_add(key_pool[i]);
        drain();
        set_config(2, 4, 1, 3);
        for (int i = 0; i < 6; i++) send_add(key_pool[$urandom_range(0, 23)]);
        send_add(rand_key());
        send_dump();
        drain();
    endtask

    // The receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        set_config(3, 16, 1, 16);
        no_gaps = 1'b1;
        hold_left = LONG_HOLD;
        for (int i = 0; i < 12; i++) send_add(key_pool[$urandom_range(0, 23)]);
        send_dump();
        no_gaps = 1'b0;
        drain();
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        for (int phase = 0; phase < 4; phase++) begin
            set_config($urandom_range(1, 8), $urandom_range(1, 40),
                       (phase != 2), $urandom_range(2, 16));
            no_gaps = (phase == 1);
            for (int i = 0; i < 20; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) send_add(key_pool[$urandom_range(0, 23)]);
                else if (pick < 72) send_add(rand_key());
                else if (pick < 82) send_query(key_pool[$urandom_range(0, 23)]);
                else if (pick < 88) send_load(3'($urandom),
                                              31'($urandom_range(0, 2147483646)),
                                              31'($urandom_range(0, 2147483646)));
                else send_dump();
            end
            no_gaps = 1'b0;
            send_dump();
            drain();
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.item_key = '0;
        req_ch.row_select = '0;
        req_ch.coeff_mult = '0;
        req_ch.coeff_offset = '0;
        for (int r = 0; r < N_ROWS; r++) begin
            sk_mult[r] = '0;
            sk_add[r] = '0;
            for (int c = 0; c < N_COLS; c++) sk_count[r][c] = '0;
        end
        for (int i = 0; i < N_LIST; i++) begin
            list_key[i] = '0;
            list_cnt[i] = '0;
        end
        list_fill = 0;
        reg_rows = 7;
        reg_cols = 91;
        reg_track = 1;
        reg_topk = 16;
        key_pool[0] = 64'd0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        for (int i = 3; i < 24; i++) key_pool[i] = rand_key();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_requests();
        test_counting_only();
        test_register_extremes();
        test_shrunk_list();
        test_backpressure();
        test_random_traffic();

        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("count_min_sketch_topk: match");
        end else begin
            $display("count_min_sketch_topk: mismatch");
        end
        $finish;
    end

endmodule
